@@ sv/rrl_pkg.sv @@
// types, codes and constants shared by the round-robin ready list modules
package rrl_pkg;

  localparam int IdW    = 4;
  localparam int NumIds = 2 ** IdW;
  localparam int OpW    = 2;
  localparam int StW    = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADMIT  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_EXEC,
    S_LINK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [IdW-1:0] thr_id;
  } rrl_in_t;

  typedef struct packed {
    logic [IdW-1:0] next_id;
    logic [StW-1:0] status;
  } rrl_out_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic exec;
    logic link;
    logic emit;
  } rrl_cmd_t;

  typedef struct packed {
    logic need_link;
  } rrl_sts_t;

endpackage

@@ sv/round_robin_ready_list.sv @@
// top level of the round-robin ready list
//
//   channel  direction  beat        handshake
//   in       input      rrl_in_t    in_valid_i / in_stall_o
//   out      output     rrl_out_t   out_valid_o / out_stall_i
//
// a request passes through the load, issue, exec and final load steps, with a link step
// added for an admit into a non-empty ring (second link-table write), set by the registered table
// read and the single write port of each link table
// the result register lets the next request be accepted while a result waits
// a waiting result stalls only the final load step of the following request
// reset clears membership and ring pointers at once, no clearing pass
module round_robin_ready_list #(
  parameter int MAX_THREADS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rrl_pkg::rrl_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rrl_pkg::rrl_out_t out_data_o
);
  import rrl_pkg::*;

  rrl_cmd_t cmd;
  rrl_sts_t sts;

  rrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrl_dpath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous still in progress");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten before its beat was taken");

  a_empty_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_EMPTY)) |-> (out_data_o.next_id == '0))
    else $error("empty pool result carries a thread id");

endmodule

@@ sv/rrl_ctrl.sv @@
// controller state machine sequencing one request through the datapath
module rrl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  rrl_pkg::rrl_sts_t sts_i,
  output rrl_pkg::rrl_cmd_t cmd_o
);
  import rrl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_link ? S_LINK : S_FIN;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);
  end

endmodule

@@ sv/rrl_dpath.sv @@
// datapath: link tables, membership bits, ring pointers and result registers
module rrl_dpath #(
  parameter int MAX_THREADS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrl_pkg::rrl_in_t  in_data_i,
  input  rrl_pkg::rrl_cmd_t cmd_i,
  output rrl_pkg::rrl_sts_t sts_o,
  output rrl_pkg::rrl_out_t out_data_o
);
  import rrl_pkg::*;

  localparam int Depth = (MAX_THREADS < NumIds) ? MAX_THREADS : NumIds;
  localparam int IdxW  = $clog2(Depth);

  logic [IdW-1:0] succ_mem [Depth];
  logic [IdW-1:0] pred_mem [Depth];

  logic [OpW-1:0]   op_q;
  logic [IdW-1:0]   id_q;
  logic [IdW-1:0]   succ_rd_q, pred_rd_q;
  logic [Depth-1:0] member_q, member_d;
  logic [IdW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [IdW-1:0]   running_q, running_d, resume_q, resume_d;
  logic             pending_q, pending_d;
  logic [IdW-1:0]   res_next_q, res_next_d;
  logic [StW-1:0]   res_status_q, res_status_d;
  rrl_out_t         out_q;

  logic [IdxW-1:0]  id_ix, succ_ra;
  logic             usable, hit;
  logic             succ_we, pred_we;
  logic [IdxW-1:0]  succ_wa, pred_wa;
  logic [IdW-1:0]   succ_wd, pred_wd;

  assign id_ix   = id_q[IdxW-1:0];
  assign usable  = (id_q != '0) && (32'(id_q) < Depth);
  assign hit     = member_q[id_ix];
  assign succ_ra = (op_q == OP_NEXT) ? running_q[IdxW-1:0] : id_ix;

  assign sts_o.need_link = (op_q == OP_ADMIT) && usable && !hit && (head_q != '0);
  assign out_data_o      = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_data_i.op;
      id_q <= in_data_i.thr_id;
    end
    if (cmd_i.emit) begin
      out_q.next_id <= res_next_q;
      out_q.status  <= res_status_q;
    end
    res_next_q   <= res_next_d;
    res_status_q <= res_status_d;
  end

  // link tables
  always_ff @(posedge clk_i) begin
    if (succ_we) succ_mem[succ_wa] <= succ_wd;
    if (cmd_i.issue) succ_rd_q <= succ_mem[succ_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    if (cmd_i.issue) pred_rd_q <= pred_mem[id_ix];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q  <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      running_q <= '0;
      resume_q  <= '0;
      pending_q <= 1'b0;
    end else begin
      member_q  <= member_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      running_q <= running_d;
      resume_q  <= resume_d;
      pending_q <= pending_d;
    end
  end

  always_comb begin
    member_d     = member_q;
    head_d       = head_q;
    tail_d       = tail_q;
    running_d    = running_q;
    resume_d     = resume_q;
    pending_d    = pending_q;
    res_next_d   = res_next_q;
    res_status_d = res_status_q;
    succ_we      = 1'b0;
    succ_wa      = '0;
    succ_wd      = '0;
    pred_we      = 1'b0;
    pred_wa      = '0;
    pred_wd      = '0;
    if (cmd_i.exec) begin
      res_next_d   = '0;
      res_status_d = ST_IGNORED;
      case (op_q)
        OP_ADMIT: begin
          if (usable && !hit) begin
            res_status_d    = ST_DONE;
            member_d[id_ix] = 1'b1;
            tail_d          = id_q;
            if (head_q == '0) begin
              head_d  = id_q;
              succ_we = 1'b1;
              succ_wa = id_ix;
              succ_wd = id_q;
              pred_we = 1'b1;
              pred_wa = id_ix;
              pred_wd = id_q;
            end else begin
              succ_we = 1'b1;
              succ_wa = tail_q[IdxW-1:0];
              succ_wd = id_q;
              pred_we = 1'b1;
              pred_wa = id_ix;
              pred_wd = tail_q;
            end
          end
        end
        OP_REMOVE: begin
          if (usable && hit) begin
            res_status_d    = ST_DONE;
            member_d[id_ix] = 1'b0;
            if (head_q == tail_q) begin
              head_d    = '0;
              tail_d    = '0;
              running_d = '0;
              resume_d  = '0;
              pending_d = 1'b0;
            end else begin
              succ_we = 1'b1;
              succ_wa = pred_rd_q[IdxW-1:0];
              succ_wd = succ_rd_q;
              pred_we = 1'b1;
              pred_wa = succ_rd_q[IdxW-1:0];
              pred_wd = pred_rd_q;
              if (head_q == id_q) head_d = succ_rd_q;
              if (tail_q == id_q) tail_d = pred_rd_q;
              if (running_q == id_q) begin
                running_d = '0;
                resume_d  = succ_rd_q;
                pending_d = 1'b1;
              end else if (pending_q && (resume_q == id_q)) begin
                resume_d = succ_rd_q;
              end
            end
          end
        end
        OP_NEXT: begin
          if (head_q == '0) begin
            running_d    = '0;
            resume_d     = '0;
            pending_d    = 1'b0;
            res_status_d = ST_EMPTY;
          end else begin
            res_status_d = ST_DONE;
            if (pending_q) begin
              running_d = resume_q;
              resume_d  = '0;
              pending_d = 1'b0;
            end else if (running_q == '0) begin
              running_d = head_q;
            end else begin
              running_d = succ_rd_q;
            end
            res_next_d = running_d;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.link) begin
      // close the ring behind a new tail
      succ_we = 1'b1;
      succ_wa = id_ix;
      succ_wd = head_q;
      pred_we = 1'b1;
      pred_wa = head_q[IdxW-1:0];
      pred_wd = id_q;
    end
  end

endmodule

@@ tb/round_robin_ready_list_tb.sv @@
// testbench for the round-robin ready list: ring tracker, directed and random requests and result checks
module round_robin_ready_list_tb;
  import rrl_pkg::*;

  localparam int ClkPeriod      = 8;
  localparam int MaxThreads     = 16;
  localparam int TimeoutCycles  = 200000;
  localparam int HoldOffCycles  = 150;
  localparam int RandomPerPhase = 100;
  localparam int DrainCycles    = 12;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  class ring_tracker;
    logic [IdW-1:0] succ_tbl [NumIds];
    logic [IdW-1:0] pred_tbl [NumIds];
    bit             in_ring  [NumIds];
    logic [IdW-1:0] head_id;
    logic [IdW-1:0] tail_id;
    logic [IdW-1:0] running_id;
    logic [IdW-1:0] resume_id;
    bit             resume_pending;
    rrl_out_t       due_results [$];
    int             failures;

    function new();
      foreach (in_ring[i]) begin
        in_ring[i]  = 1'b0;
        succ_tbl[i] = '0;
        pred_tbl[i] = '0;
      end
      head_id        = '0;
      tail_id        = '0;
      running_id     = '0;
      resume_id      = '0;
      resume_pending = 1'b0;
      failures       = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_request(rrl_in_t req);
      rrl_out_t       res;
      logic [IdW-1:0] tid;
      logic [IdW-1:0] p;
      logic [IdW-1:0] s;
      bit             usable;
      tid        = req.thr_id;
      usable     = (tid != '0) && (int'(tid) < MaxThreads);
      res.next_id = '0;
      res.status  = ST_IGNORED;
      case (req.op)
        OP_ADMIT: begin
          if (usable && !in_ring[tid]) begin
            if (head_id == '0) begin
              head_id       = tid;
              tail_id       = tid;
              succ_tbl[tid] = tid;
              pred_tbl[tid] = tid;
            end else begin
              succ_tbl[tail_id] = tid;
              pred_tbl[tid]     = tail_id;
              succ_tbl[tid]     = head_id;
              pred_tbl[head_id] = tid;
              tail_id           = tid;
            end
            in_ring[tid] = 1'b1;
            res.status   = ST_DONE;
          end
        end
        OP_REMOVE: begin
          if (usable && in_ring[tid]) begin
            in_ring[tid] = 1'b0;
            res.status   = ST_DONE;
            if (head_id == tail_id) begin
              head_id        = '0;
              tail_id        = '0;
              running_id     = '0;
              resume_id      = '0;
              resume_pending = 1'b0;
            end else begin
              p           = pred_tbl[tid];
              s           = succ_tbl[tid];
              succ_tbl[p] = s;
              pred_tbl[s] = p;
              if (head_id == tid) head_id = s;
              if (tail_id == tid) tail_id = p;
              if (running_id == tid) begin
                running_id     = '0;
                resume_id      = s;
                resume_pending = 1'b1;
              end else if (resume_pending && resume_id == tid) begin
                resume_id = s;
              end
            end
          end
        end
        OP_NEXT: begin
          if (head_id == '0) begin
            running_id     = '0;
            resume_id      = '0;
            resume_pending = 1'b0;
            res.status     = ST_EMPTY;
          end else begin
            if (resume_pending) begin
              running_id     = resume_id;
              resume_id      = '0;
              resume_pending = 1'b0;
            end else if (running_id == '0 || int'(running_id) >= MaxThreads) begin
              running_id = head_id;
            end else begin
              running_id = succ_tbl[running_id];
            end
            res.next_id = running_id;
            res.status  = ST_DONE;
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
      due_results.push_back(res);
    endfunction

    function void flag(string what, int exp_v, int got_v);
      failures++;
      if (failures <= 10) begin
        $display("mismatch %0s: expected %0d, actual %0d at %0t", what, exp_v, got_v, $time);
      end
    endfunction

    function void check_result(rrl_out_t got);
      rrl_out_t want;
      if (due_results.size() == 0) begin
        flag("unexpected beat, next_id", -1, int'(got.next_id));
        return;
      end
      want = due_results.pop_front();
      if (got.next_id !== want.next_id) begin
        flag("next_id", int'(want.next_id), int'(got.next_id));
      end
      if (got.status !== want.status) begin
        flag("status", int'(want.status), int'(got.status));
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  rrl_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rrl_out_t out_data_o;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int          hold_left      = 0;
  ring_tracker sb             = new();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  round_robin_ready_list #(
    .MAX_THREADS(MaxThreads)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  task automatic send_req(input logic [OpW-1:0] op, input logic [IdW-1:0] tid);
    rrl_in_t req;
    req.op     = op;
    req.thr_id = tid;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic run_directed();
    send_req(OP_NEXT, 4'd15);
    send_req(OP_ADMIT, 4'd0);
    send_req(OP_REMOVE, 4'd5);
    send_req(OP_ADMIT, 4'd1);
    send_req(OP_ADMIT, 4'd15);
    send_req(OP_ADMIT, 4'd8);
    send_req(OP_ADMIT, 4'd15);
    send_req(OP_NEXT, 4'd0);
    send_req(OP_NEXT, 4'd0);
    // drop the current thread, then the thread it resumes at
    send_req(OP_REMOVE, 4'd15);
    send_req(OP_REMOVE, 4'd8);
    send_req(OP_ADMIT, 4'd10);
    send_req(OP_NEXT, 4'd0);
    send_req(OP_NEXT, 4'd15);
    send_req(OpUnused, 4'd15);
    send_req(OP_REMOVE, 4'd0);
    send_req(OP_REMOVE, 4'd10);
    send_req(OP_REMOVE, 4'd1);
    send_req(OP_NEXT, 4'd0);
    send_req(OP_ADMIT, 4'd7);
    send_req(OP_NEXT, 4'd0);
    send_req(OP_NEXT, 4'd0);
    send_req(OP_REMOVE, 4'd7);
    send_req(OpUnused, 4'd0);
  endtask

  task automatic run_random(input int count);
    int pick;
    int remove_pct;
    for (int i = 0; i < count; i++) begin
      // alternate between filling and draining the ring
      remove_pct = ((i / 25) % 2 == 1) ? 45 : 20;
      pick       = $urandom_range(99);
      if (pick < 4) begin
        send_req(OpUnused, IdW'($urandom));
      end else if (pick < 8) begin
        send_req((pick % 2 == 0) ? OP_ADMIT : OP_REMOVE, 4'd0);
      end else if (pick < 8 + remove_pct) begin
        send_req(OP_REMOVE, IdW'($urandom_range(NumIds - 1, 1)));
      end else if (pick < 38 + remove_pct) begin
        send_req(OP_NEXT, IdW'($urandom));
      end else begin
        send_req(OP_ADMIT, IdW'($urandom_range(NumIds - 1, 1)));
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      run_random(RandomPerPhase);
    end
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
